// ===== design/tcpq_pkg.sv =====
`timescale 1ns / 1ps
package tcpq_pkg;

    // Defaults and fixed field widths
    localparam int DEPTH_DEFAULT = 8;
    localparam int PAYLOAD_W     = 32;
    localparam int FILL_W        = 4;
    localparam int STATUS_W      = 2;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Request codes
    typedef enum logic {
        REQ_PUSH = 1'b0,
        REQ_POP  = 1'b1
    } req_t;

    // Controller states
    typedef enum logic {
        S_IDLE,
        S_APPLY
    } ctrl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic commit;
    } dp_cmd_t;

endpackage

// ===== design/tcpq_ctrl.sv =====
`timescale 1ns / 1ps
module tcpq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output tcpq_pkg::dp_cmd_t cmd
);
    import tcpq_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    // Output register can take a new item when empty or being drained
    assign out_free = !out_valid_reg || !out_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs and commands
    always_comb
    begin
        in_stall    = 1'b1;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            S_APPLY:
            begin
                cmd.commit = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Hold result valid until taken, set on commit
    always_comb
    begin
        priority if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== design/tcpq_datapath.sv =====
`timescale 1ns / 1ps
module tcpq_datapath #(
    parameter int QUEUE_DEPTH = tcpq_pkg::DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tcpq_pkg::dp_cmd_t               cmd,
    input  logic                            cfg_we,
    input  logic                            cfg_data,
    input  logic                            req_type,
    input  logic [tcpq_pkg::PAYLOAD_W-1:0]  entry_payload,
    input  logic                            entry_urgent,
    input  logic                            entry_is_stop,
    output logic [tcpq_pkg::STATUS_W-1:0]   status,
    output logic [tcpq_pkg::PAYLOAD_W-1:0]  out_payload,
    output logic                            out_urgent,
    output logic                            out_is_stop,
    output logic [tcpq_pkg::FILL_W-1:0]     fill_level
);
    import tcpq_pkg::*;

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Slots held in age order, slot 0 is the oldest
    logic [PAYLOAD_W-1:0] slot_payload_reg [QUEUE_DEPTH];
    logic                 slot_urgent_reg  [QUEUE_DEPTH];
    logic                 slot_stop_reg    [QUEUE_DEPTH];

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 prefer_reg;
    logic [IDX_W-1:0]     pick_reg;
    logic [IDX_W-1:0]     pick_next;
    logic                 found_reg;
    logic                 found_next;

    // Captured request
    req_t                 req_type_reg;
    logic [PAYLOAD_W-1:0] req_payload_reg;
    logic                 req_urgent_reg;
    logic                 req_stop_reg;

    // Result register
    status_t              status_reg;
    status_t              status_next;
    logic [PAYLOAD_W-1:0] res_payload_reg;
    logic [PAYLOAD_W-1:0] res_payload_next;
    logic                 res_urgent_reg;
    logic                 res_urgent_next;
    logic                 res_stop_reg;
    logic                 res_stop_next;
    logic [FILL_W-1:0]    fill_reg;

    logic [QUEUE_DEPTH-1:0] cand;
    logic [IDX_W-1:0]       take_idx;
    logic                   is_full;
    logic                   is_empty;
    logic                   do_push;
    logic                   do_pop;

    // Flag occupied urgent entries that are not stop markers
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            cand[i] = slot_urgent_reg[i] && !slot_stop_reg[i] && (CNT_W'(i) < count_reg);
        end
    end

    // Find the oldest candidate, registered for the apply cycle
    always_comb
    begin
        pick_next  = '0;
        found_next = 1'b0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                pick_next  = IDX_W'(i);
                found_next = 1'b1;
            end
        end
    end

    assign is_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign is_empty = (count_reg == '0);
    assign do_push  = cmd.commit && (req_type_reg == REQ_PUSH) && !is_full;
    assign do_pop   = cmd.commit && (req_type_reg == REQ_POP) && !is_empty;
    assign take_idx = (prefer_reg && found_reg) ? pick_reg : '0;

    // Result fields and new fill count
    always_comb
    begin
        status_next      = ST_DONE;
        res_payload_next = '0;
        res_urgent_next  = 1'b0;
        res_stop_next    = 1'b0;
        count_next       = count_reg;
        unique case (req_type_reg)
            REQ_PUSH:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            REQ_POP:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    count_next       = count_reg - CNT_W'(1);
                    res_payload_next = slot_payload_reg[take_idx];
                    res_urgent_next  = slot_urgent_reg[take_idx];
                    res_stop_next    = slot_stop_reg[take_idx];
                end
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            prefer_reg <= 1'b1;
            pick_reg   <= '0;
            found_reg  <= 1'b0;
        end
        else
        begin
            pick_reg  <= pick_next;
            found_reg <= found_next;
            if (cfg_we)
            begin
                prefer_reg <= cfg_data;
            end
            if (cmd.commit)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Capture request, load result
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_type_reg    <= req_t'(req_type);
            req_payload_reg <= entry_payload;
            req_urgent_reg  <= entry_urgent;
            req_stop_reg    <= entry_is_stop;
        end
        if (cmd.commit)
        begin
            status_reg      <= status_next;
            res_payload_reg <= res_payload_next;
            res_urgent_reg  <= res_urgent_next;
            res_stop_reg    <= res_stop_next;
            fill_reg        <= FILL_W'(count_next);
        end
    end

    // Per slot: write at tail on push, close the gap on pop
    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_slot
        logic is_tail;

        assign is_tail = (CNT_W'(g) == count_reg);

        if (g < QUEUE_DEPTH - 1)
        begin : g_mid
            logic shift_in;

            assign shift_in = (CNT_W'(g) >= CNT_W'(take_idx))
                              && ((CNT_W'(g) + CNT_W'(1)) < count_reg);

            always_ff @(posedge clk)
            begin
                priority if (do_push && is_tail)
                begin
                    slot_payload_reg[g] <= req_payload_reg;
                    slot_urgent_reg[g]  <= req_urgent_reg;
                    slot_stop_reg[g]    <= req_stop_reg;
                end
                else if (do_pop && shift_in)
                begin
                    slot_payload_reg[g] <= slot_payload_reg[g+1];
                    slot_urgent_reg[g]  <= slot_urgent_reg[g+1];
                    slot_stop_reg[g]    <= slot_stop_reg[g+1];
                end
            end
        end
        else
        begin : g_last
            always_ff @(posedge clk)
            begin
                if (do_push && is_tail)
                begin
                    slot_payload_reg[g] <= req_payload_reg;
                    slot_urgent_reg[g]  <= req_urgent_reg;
                    slot_stop_reg[g]    <= req_stop_reg;
                end
            end
        end
    end

    assign status      = status_reg;
    assign out_payload = res_payload_reg;
    assign out_urgent  = res_urgent_reg;
    assign out_is_stop = res_stop_reg;
    assign fill_level  = fill_reg;

endmodule

// ===== design/two_class_priority_ring_queue.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   req_type, entry_payload, entry_urgent, entry_is_stop
// out      output     out_valid / out_stall status, out_payload, out_urgent, out_is_stop, fill_level
// cfg      input      cfg_valid / cfg_ready cfg_data (prefer_urgent)
//
// Each request is accepted in the idle state while the oldest urgent entry
// is found, then the apply state does the push or pop and loads the result register.
// A new request is taken while the previous result still waits at the output.
// A stalled output holds the apply cycle until the result register frees up.
// Reset empties the queue and sets urgent preference; cfg_ready is always high.
module two_class_priority_ring_queue #(
    parameter int QUEUE_DEPTH = tcpq_pkg::DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            req_type,
    input  logic [tcpq_pkg::PAYLOAD_W-1:0]  entry_payload,
    input  logic                            entry_urgent,
    input  logic                            entry_is_stop,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [tcpq_pkg::STATUS_W-1:0]   status,
    output logic [tcpq_pkg::PAYLOAD_W-1:0]  out_payload,
    output logic                            out_urgent,
    output logic                            out_is_stop,
    output logic [tcpq_pkg::FILL_W-1:0]     fill_level,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_data
);
    import tcpq_pkg::*;

    dp_cmd_t cmd;

    assign cfg_ready = 1'b1;

    // Sequence the request
    tcpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Store, search and compact
    tcpq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .req_type      (req_type),
        .entry_payload (entry_payload),
        .entry_urgent  (entry_urgent),
        .entry_is_stop (entry_is_stop),
        .status        (status),
        .out_payload   (out_payload),
        .out_urgent    (out_urgent),
        .out_is_stop   (out_is_stop),
        .fill_level    (fill_level)
    );

endmodule

// ===== bench/tcpq_checker.sv =====
`timescale 1ns / 1ps
module tcpq_checker #(
    parameter int QUEUE_DEPTH = tcpq_pkg::DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            req_type,
    input  logic [tcpq_pkg::PAYLOAD_W-1:0]  entry_payload,
    input  logic                            entry_urgent,
    input  logic                            entry_is_stop,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [tcpq_pkg::STATUS_W-1:0]   status,
    input  logic [tcpq_pkg::PAYLOAD_W-1:0]  out_payload,
    input  logic                            out_urgent,
    input  logic                            out_is_stop,
    input  logic [tcpq_pkg::FILL_W-1:0]     fill_level,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic                            cfg_data,
    output int                              fail_count,
    output int                              outstanding
);
    import tcpq_pkg::*;

    localparam int REPORT_LIMIT = 100;

    typedef struct packed {
        logic [PAYLOAD_W-1:0] payload;
        logic                 urgent;
        logic                 is_stop;
    } queue_entry_t;

    typedef struct packed {
        status_t              status;
        logic [PAYLOAD_W-1:0] payload;
        logic                 urgent;
        logic                 is_stop;
        logic [FILL_W-1:0]    fill;
    } response_t;

    // Shadow copy of the queue and its register
    queue_entry_t shadow_slots [QUEUE_DEPTH];
    int           head_pos;
    int           tail_pos;
    int           held_count;
    logic         urgent_first;
    response_t    expected_responses [$];
    int           reports;

    // Apply one request to the shadow queue and return its response
    function automatic response_t apply_request(req_t kind, logic [PAYLOAD_W-1:0] pay,
                                                logic urg, logic stp);
        response_t    resp;
        queue_entry_t taken;
        int           pick;
        int           i;
        bit           found;
        resp        = '0;
        resp.status = ST_DONE;
        if (kind == REQ_PUSH) begin
            if (held_count >= QUEUE_DEPTH) begin
                resp.status = ST_FULL;
            end
            else begin
                shadow_slots[tail_pos] = '{payload: pay, urgent: urg, is_stop: stp};
                tail_pos   = (tail_pos + 1) % QUEUE_DEPTH;
                held_count = held_count + 1;
            end
        end
        else if (held_count == 0) begin
            resp.status = ST_EMPTY;
        end
        else begin
            // Find the oldest urgent entry that is not a stop marker
            pick  = 0;
            found = 1'b0;
            if (urgent_first) begin
                for (i = 0; i < held_count; i++) begin
                    if (!found && shadow_slots[(head_pos + i) % QUEUE_DEPTH].urgent &&
                        !shadow_slots[(head_pos + i) % QUEUE_DEPTH].is_stop) begin
                        pick  = i;
                        found = 1'b1;
                    end
                end
            end
            taken = shadow_slots[(head_pos + pick) % QUEUE_DEPTH];
            // Shift the older entries up over the gap, then advance the head
            for (i = pick; i > 0; i--) begin
                shadow_slots[(head_pos + i) % QUEUE_DEPTH] =
                    shadow_slots[(head_pos + i - 1) % QUEUE_DEPTH];
            end
            head_pos     = (head_pos + 1) % QUEUE_DEPTH;
            held_count   = held_count - 1;
            resp.payload = taken.payload;
            resp.urgent  = taken.urgent;
            resp.is_stop = taken.is_stop;
        end
        resp.fill = held_count[FILL_W-1:0];
        return resp;
    endfunction

    // Report one field mismatch, with a cap on printed lines
    task automatic report_field(string field, longint unsigned want, longint unsigned got);
        fail_count = fail_count + 1;
        if (reports < REPORT_LIMIT) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, field, want, got);
        end
        reports = reports + 1;
    endtask

    // Watch the channels, predict on accepted requests, compare accepted results
    always @(posedge clk or negedge rst_n) begin
        response_t want;
        if (!rst_n) begin
            for (int s = 0; s < QUEUE_DEPTH; s++) begin
                shadow_slots[s] = '0;
            end
            head_pos     = 0;
            tail_pos     = 0;
            held_count   = 0;
            urgent_first = 1'b1;
            expected_responses.delete();
            outstanding <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                urgent_first = cfg_data;
            end
            if (out_valid && !out_stall) begin
                if (expected_responses.size() == 0) begin
                    fail_count = fail_count + 1;
                    if (reports < REPORT_LIMIT) begin
                        $display("%0t: unexpected result, expected none, got status %0d",
                                 $realtime, status);
                    end
                    reports = reports + 1;
                end
                else begin
                    want = expected_responses.pop_front();
                    if (status !== want.status)
                        report_field("status", want.status, status);
                    if (out_payload !== want.payload)
                        report_field("out_payload", want.payload, out_payload);
                    if (out_urgent !== want.urgent)
                        report_field("out_urgent", want.urgent, out_urgent);
                    if (out_is_stop !== want.is_stop)
                        report_field("out_is_stop", want.is_stop, out_is_stop);
                    if (fill_level !== want.fill)
                        report_field("fill_level", want.fill, fill_level);
                end
            end
            if (in_valid && !in_stall) begin
                expected_responses.push_back(apply_request(req_t'(req_type), entry_payload,
                                                           entry_urgent, entry_is_stop));
            end
            outstanding <= expected_responses.size();
        end
    end

    initial begin
        fail_count = 0;
        reports    = 0;
    end

endmodule

// ===== bench/tb_two_class_priority_ring_queue.sv =====
`timescale 1ns / 1ps
module tb_two_class_priority_ring_queue;
    import tcpq_pkg::*;

    localparam int DEPTH        = DEPTH_DEFAULT;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 225;
    localparam int DRAIN_CYCLES = 4;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 req_type;
    logic [PAYLOAD_W-1:0] entry_payload;
    logic                 entry_urgent;
    logic                 entry_is_stop;
    logic                 out_valid;
    logic                 out_stall;
    logic [STATUS_W-1:0]  status;
    logic [PAYLOAD_W-1:0] out_payload;
    logic                 out_urgent;
    logic                 out_is_stop;
    logic [FILL_W-1:0]    fill_level;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic                 cfg_data;
    int                   fail_count;
    int                   outstanding;
    bit                   quiet_in;
    bit                   quiet_out;

    two_class_priority_ring_queue #(.QUEUE_DEPTH(DEPTH)) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .entry_payload(entry_payload),
        .entry_urgent (entry_urgent),
        .entry_is_stop(entry_is_stop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .out_payload  (out_payload),
        .out_urgent   (out_urgent),
        .out_is_stop  (out_is_stop),
        .fill_level   (fill_level),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    tcpq_checker #(.QUEUE_DEPTH(DEPTH)) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .entry_payload(entry_payload),
        .entry_urgent (entry_urgent),
        .entry_is_stop(entry_is_stop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .out_payload  (out_payload),
        .out_urgent   (out_urgent),
        .out_is_stop  (out_is_stop),
        .fill_level   (fill_level),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    // Free-running clock, 4 ns period
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Pick an idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offer one item after an optional gap and hold it until accepted
    task automatic send_item(req_t kind, logic [PAYLOAD_W-1:0] pay, logic urg, logic stp);
        int gap;
        gap = quiet_in ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        req_type      <= kind;
        entry_payload <= pay;
        entry_urgent  <= urg;
        entry_is_stop <= stp;
        do @(posedge clk); while (in_stall);
    endtask

    // Wait until every result is back, then let the pipeline settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the urgent preference register
    task automatic write_pref(logic value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Random request with occasional extreme payloads
    task automatic send_random(int push_pct);
        logic [PAYLOAD_W-1:0] pay;
        int                   r;
        r = $urandom_range(0, 19);
        if (r == 0)
            pay = '0;
        else if (r == 1)
            pay = '1;
        else
            pay = $urandom;
        send_item(($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_POP, pay,
                  $urandom_range(0, 99) < 40, $urandom_range(0, 99) < 20);
    endtask

    // Drive the output stall in random bursts
    initial
    begin
        int run;
        out_stall = 1'b0;
        forever begin
            run = quiet_out ? 0 : pick_gap();
            if (run > 0) begin
                out_stall <= 1'b1;
                repeat (run) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // Main stimulus and verdict
    initial
    begin
        int push_pct;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        req_type      = REQ_PUSH;
        entry_payload = '0;
        entry_urgent  = 1'b0;
        entry_is_stop = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = 1'b0;
        quiet_in      = 1'b0;
        quiet_out     = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: urgent preference on
        write_pref(1'b1);
        send_item(REQ_POP, 32'h0, 1'b0, 1'b0);
        send_item(REQ_PUSH, 32'h0000_0000, 1'b0, 1'b0);
        send_item(REQ_PUSH, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_item(REQ_PUSH, 32'hA5A5_A5A5, 1'b1, 1'b0);
        send_item(REQ_PUSH, 32'h5A5A_5A5A, 1'b0, 1'b1);
        // Take the urgent entry past the urgent stop marker
        send_item(REQ_POP, 32'hFFFF_FFFF, 1'b1, 1'b1);
        // Fill up, then push once more into a full queue
        for (int n = 0; n < 5; n++) begin
            send_item(REQ_PUSH, 32'h1000_0000 + n, n[0], n[1]);
        end
        send_item(REQ_PUSH, 32'hDEAD_BEEF, 1'b1, 1'b0);
        // Empty it and pop once more from an empty queue
        for (int n = 0; n < DEPTH + 1; n++) begin
            send_item(REQ_POP, 32'h0, 1'b0, 1'b0);
        end
        wait_drained();

        // Directed: plain FIFO
        write_pref(1'b0);
        send_item(REQ_PUSH, 32'h1234_5678, 1'b0, 1'b0);
        send_item(REQ_PUSH, 32'h8765_4321, 1'b1, 1'b0);
        send_item(REQ_POP, 32'h0, 1'b0, 1'b0);
        wait_drained();

        // Random phases with alternating preference and idling modes
        for (int p = 0; p < PHASES; p++) begin
            write_pref(p[0]);
            quiet_in  = (p == 2);
            quiet_out = (p == 2) || (p == 4);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 20 == 0) begin
                    case ($urandom_range(0, 3))
                        0:       push_pct = 20;
                        1:       push_pct = 50;
                        2:       push_pct = 80;
                        default: push_pct = 95;
                    endcase
                end
                send_random(push_pct);
            end
            wait_drained();
        end

        if (fail_count == 0)
            $display("tb_two_class_priority_ring_queue OK");
        else
            $display("tb_two_class_priority_ring_queue NOT OK");
        $finish;
    end

    // Hard limit on run length
    initial
    begin
        #4_000_000;
        $display("tb_two_class_priority_ring_queue NOT OK");
        $finish;
    end

endmodule
